>>> design/pfa_pkg.sv
package pfa_pkg;

	// Command codes of the request channel.
	localparam int CMD_W = 3;
	localparam logic [CMD_W-1:0] CMD_ADD = 3'd0;
	localparam logic [CMD_W-1:0] CMD_SUB = 3'd1;
	localparam logic [CMD_W-1:0] CMD_MUL = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DIV = 3'd3;
	localparam logic [CMD_W-1:0] CMD_POW = 3'd4;
	localparam logic [CMD_W-1:0] CMD_NEG = 3'd5;

	// Width of the signed exponent / second operand.
	localparam int OPB_W = 32;

	// Operations of the shared arithmetic unit.
	typedef enum logic [1:0] {
		UOP_ADDM = 2'd0,
		UOP_SUBM = 2'd1,
		UOP_DIVS = 2'd2
	} pfa_uop_t;

	// Control word from the sequencer to the arithmetic unit.
	typedef struct packed {
		pfa_uop_t op;
		logic     bit_in;
	} pfa_uctl_t;

endpackage

>>> design/pfa_if.sv
// Request channel: command and two operands.
interface pfa_req_if #(
	parameter int VALUE_WIDTH = 31
);
	logic                            valid;
	logic                            ready;
	logic [pfa_pkg::CMD_W-1:0]       cmd;
	logic [VALUE_WIDTH-1:0]          operand_a;
	logic signed [pfa_pkg::OPB_W-1:0] operand_b;

	modport source(output valid, cmd, operand_a, operand_b, input ready);
	modport sink(input valid, cmd, operand_a, operand_b, output ready);
endinterface

// Response channel: residue, error and compare flags.
interface pfa_rsp_if #(
	parameter int VALUE_WIDTH = 31
);
	logic                   valid;
	logic                   ready;
	logic [VALUE_WIDTH-1:0] result;
	logic                   error;
	logic                   is_equal;
	logic                   is_less;

	modport source(output valid, result, error, is_equal, is_less, input ready);
	modport sink(input valid, result, error, is_equal, is_less, output ready);
endinterface

>>> design/pfa_unit.sv
// Shared arithmetic unit: modular add, modular subtract, or one restoring
// shift-subtract step of a division.
module pfa_unit #(
	parameter int VALUE_WIDTH = 31
) (
	input  pfa_pkg::pfa_uctl_t      ctl,
	input  logic [VALUE_WIDTH-1:0]  x,
	input  logic [VALUE_WIDTH-1:0]  y,
	input  logic [VALUE_WIDTH-1:0]  m,
	output logic [VALUE_WIDTH-1:0]  res,
	output logic                    flag
);

	localparam int W = VALUE_WIDTH;

	logic [W:0] sum;
	logic [W:0] dif;
	logic [W:0] shl;
	logic [W:0] red;

	always_comb begin
		sum  = {1'b0, x} + {1'b0, y};
		dif  = {1'b0, x} - {1'b0, y};
		shl  = {x, ctl.bit_in};
		red  = '0;
		res  = '0;
		flag = 1'b0;
		unique case (ctl.op)
			pfa_pkg::UOP_ADDM: begin
				// Sum of two residues, folded back below m.
				red  = sum - {1'b0, m};
				flag = (sum >= {1'b0, m});
				res  = flag ? red[W-1:0] : sum[W-1:0];
			end
			pfa_pkg::UOP_SUBM: begin
				// Difference of two residues; add m back on borrow.
				red  = dif + {1'b0, m};
				flag = (x < y);
				res  = flag ? red[W-1:0] : dif[W-1:0];
			end
			pfa_pkg::UOP_DIVS: begin
				// Shift in the next dividend bit and subtract the divisor if it fits.
				red  = shl - {1'b0, m};
				flag = (shl >= {1'b0, m});
				res  = flag ? red[W-1:0] : shl[W-1:0];
			end
			default: begin
				res  = '0;
				flag = 1'b0;
			end
		endcase
	end

endmodule

>>> design/prime_field_alu_core.sv
// Arithmetic unit over GF(p), with p held in the modulus register.
// A request on req carries cmd (add, sub, mul, div, pow, negate a), operand_a
// and the signed operand_b. The response on rsp carries the canonical residue,
// an error flag (division by zero, zero to a negative power, or no inverse)
// and the equal and less-than flags of reduced a against reduced b.
// The user must write the modulus via modulus_we / modulus_wdata only while
// the block is idle; the block does not enforce it. Reset loads 2147483647
// (truncated to VALUE_WIDTH) and empties rsp. All work runs through one
// shared add/subtract unit, one step per cycle: a and b are reduced mod p by
// restoring division and b is negated if negative; add, sub and negate then
// finish in the execute state, and mul runs a shift-and-add modular multiply.
// A power squares, and multiplies on a set bit, over all 32 bits of the
// magnitude of b; an inverse runs one Euclid round (a division, a multiply
// and an update) per quotient, at most about 1.44*W rounds.
// req.ready is high only while the sequencer is idle, one request at a time.
// The finished response sits in an output register; when rsp stalls, the
// sequencer waits until that register is free, and a new request may be
// taken while the previous response is still waiting.
module prime_field_alu_core #(
	parameter int VALUE_WIDTH = 31
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   modulus_we,
	input  logic [VALUE_WIDTH-1:0] modulus_wdata,
	pfa_req_if.sink                req,
	pfa_rsp_if.source              rsp
);

	localparam int W   = VALUE_WIDTH;
	localparam int BW  = pfa_pkg::OPB_W;
	localparam int DW  = (W > BW) ? W : BW;
	localparam int CW  = $clog2(DW);
	localparam int MCW = (W > 2) ? $clog2(W) : 1;
	localparam logic [W-1:0] MOD_RST = W'(64'd2147483647);

	typedef enum logic [14:0] {
		S_IDLE    = 15'b000000000000001,
		S_RED_A   = 15'b000000000000010,
		S_RED_B   = 15'b000000000000100,
		S_NEG_B   = 15'b000000000001000,
		S_EXEC    = 15'b000000000010000,
		S_MUL     = 15'b000000000100000,
		S_TAKE    = 15'b000000001000000,
		S_POW_SQ  = 15'b000000010000000,
		S_POW_SQD = 15'b000000100000000,
		S_POW_ML  = 15'b000001000000000,
		S_POW_NX  = 15'b000010000000000,
		S_INV_TST = 15'b000100000000000,
		S_INV_DIV = 15'b001000000000000,
		S_INV_UPD = 15'b010000000000000,
		S_DONE    = 15'b100000000000000
	} state_t;

	state_t state_q, state_d;
	state_t ret_q, ret_d;

	logic [W-1:0]            modulus_q;
	logic [W-1:0]            p;
	logic [W-1:0]            one_p;
	logic [pfa_pkg::CMD_W-1:0] cmd_q;
	logic                    bneg_q;
	logic [BW-1:0]           bmag_q;
	logic [BW-1:0]           bmag_in;
	logic [W-1:0]            a_q, b_q, rem_q;
	logic [DW-1:0]           dv_q;
	logic [CW-1:0]           cnt_q;
	logic [W-1:0]            mx_q, my_q, prod_q;
	logic [MCW-1:0]          mcnt_q;
	logic                    mph_q;
	logic [W-1:0]            pw_q;
	logic [W-1:0]            r0_q, r1_q, t0_q, t1_q, q_q;
	logic [W-1:0]            res_q;
	logic                    err_q;
	logic                    ovalid_q;
	logic [W-1:0]            ores_q;
	logic                    oerr_q, oeq_q, olt_q;
	logic                    req_take;
	logic                    out_load;
	logic                    mul_last;

	pfa_pkg::pfa_uctl_t      u_ctl;
	logic [W-1:0]            u_x, u_y, u_m, u_res;
	logic                    u_flag;

	// A zero modulus acts as one; 1 mod p is zero then.
	assign p     = (modulus_q == '0) ? W'(1) : modulus_q;
	assign one_p = (p == W'(1)) ? '0 : W'(1);

	assign bmag_in  = req.operand_b[BW-1] ? (~req.operand_b + BW'(1)) : req.operand_b;
	assign req.ready = (state_q == S_IDLE);
	assign req_take  = req.valid && (state_q == S_IDLE);
	assign out_load  = (state_q == S_DONE) && (!ovalid_q || rsp.ready);
	assign mul_last  = mph_q && (mcnt_q == '0);

	assign rsp.valid    = ovalid_q;
	assign rsp.result   = ores_q;
	assign rsp.error    = oerr_q;
	assign rsp.is_equal = oeq_q;
	assign rsp.is_less  = olt_q;

	// Operand selection for the shared unit.
	always_comb begin
		u_ctl.op     = pfa_pkg::UOP_ADDM;
		u_ctl.bit_in = dv_q[DW-1];
		u_x          = '0;
		u_y          = '0;
		u_m          = p;
		unique case (state_q)
			S_RED_A, S_RED_B: begin
				u_ctl.op = pfa_pkg::UOP_DIVS;
				u_x      = rem_q;
			end
			S_INV_DIV: begin
				u_ctl.op = pfa_pkg::UOP_DIVS;
				u_x      = rem_q;
				u_m      = r1_q;
			end
			S_NEG_B: begin
				u_ctl.op = pfa_pkg::UOP_SUBM;
				u_y      = rem_q;
			end
			S_EXEC: begin
				u_ctl.op = (cmd_q == pfa_pkg::CMD_ADD) ? pfa_pkg::UOP_ADDM
				                                       : pfa_pkg::UOP_SUBM;
				u_x      = (cmd_q == pfa_pkg::CMD_NEG) ? '0 : a_q;
				u_y      = (cmd_q == pfa_pkg::CMD_NEG) ? a_q : b_q;
			end
			S_MUL: begin
				// Double the accumulator, then add the multiplicand on a set bit.
				u_x = prod_q;
				u_y = mph_q ? (my_q[W-1] ? mx_q : '0) : prod_q;
			end
			S_INV_UPD: begin
				u_ctl.op = pfa_pkg::UOP_SUBM;
				u_x      = t0_q;
				u_y      = prod_q;
			end
			default: begin
				u_x = '0;
			end
		endcase
	end

	pfa_unit #(
		.VALUE_WIDTH(W)
	) u_unit (
		.ctl  (u_ctl),
		.x    (u_x),
		.y    (u_y),
		.m    (u_m),
		.res  (u_res),
		.flag (u_flag)
	);

	// Sequencer next state; multiply is a shared subroutine with a return state.
	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) state_d = S_RED_A;
			end
			S_RED_A: begin
				if (cnt_q == '0) state_d = S_RED_B;
			end
			S_RED_B: begin
				if (cnt_q == '0) state_d = S_NEG_B;
			end
			S_NEG_B: begin
				state_d = S_EXEC;
			end
			S_EXEC: begin
				unique case (cmd_q)
					pfa_pkg::CMD_MUL: begin
						state_d = S_MUL;
						ret_d   = S_TAKE;
					end
					pfa_pkg::CMD_DIV: state_d = (b_q == '0) ? S_DONE : S_INV_TST;
					pfa_pkg::CMD_POW: state_d = S_POW_SQ;
					default:          state_d = S_DONE;
				endcase
			end
			S_MUL: begin
				if (mul_last) state_d = ret_q;
			end
			S_TAKE: begin
				state_d = S_DONE;
			end
			S_POW_SQ: begin
				state_d = S_MUL;
				ret_d   = S_POW_SQD;
			end
			S_POW_SQD: begin
				if (bmag_q[BW-1]) begin
					state_d = S_MUL;
					ret_d   = S_POW_ML;
				end else begin
					state_d = S_POW_NX;
				end
			end
			S_POW_ML: begin
				state_d = S_POW_NX;
			end
			S_POW_NX: begin
				if (cnt_q != '0) begin
					state_d = S_POW_SQ;
				end else if (bneg_q && (a_q != '0)) begin
					state_d = S_INV_TST;
				end else begin
					state_d = S_DONE;
				end
			end
			S_INV_TST: begin
				if (r1_q != '0) begin
					state_d = S_INV_DIV;
				end else if ((r0_q == W'(1)) && (cmd_q == pfa_pkg::CMD_DIV)) begin
					state_d = S_MUL;
					ret_d   = S_TAKE;
				end else begin
					state_d = S_DONE;
				end
			end
			S_INV_DIV: begin
				if (cnt_q == '0) begin
					state_d = S_MUL;
					ret_d   = S_INV_UPD;
				end
			end
			S_INV_UPD: begin
				state_d = S_INV_TST;
			end
			S_DONE: begin
				if (!ovalid_q || rsp.ready) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ret_q     <= S_IDLE;
			ovalid_q  <= 1'b0;
			modulus_q <= MOD_RST;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			if (out_load) begin
				ovalid_q <= 1'b1;
			end else if (rsp.ready) begin
				ovalid_q <= 1'b0;
			end
			if (modulus_we) begin
				modulus_q <= modulus_wdata;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req_take) begin
					cmd_q  <= req.cmd;
					bneg_q <= req.operand_b[BW-1];
					bmag_q <= bmag_in;
					rem_q  <= '0;
					dv_q   <= DW'(req.operand_a) << (DW - W);
					cnt_q  <= CW'(W - 1);
					err_q  <= 1'b0;
					res_q  <= '0;
				end
			end
			S_RED_A: begin
				if (cnt_q == '0) begin
					a_q   <= u_res;
					rem_q <= '0;
					dv_q  <= DW'(bmag_q) << (DW - BW);
					cnt_q <= CW'(BW - 1);
				end else begin
					rem_q <= u_res;
					dv_q  <= dv_q << 1;
					cnt_q <= cnt_q - CW'(1);
				end
			end
			S_RED_B: begin
				rem_q <= u_res;
				dv_q  <= dv_q << 1;
				cnt_q <= cnt_q - CW'(1);
			end
			S_NEG_B: begin
				b_q <= bneg_q ? u_res : rem_q;
			end
			S_EXEC: begin
				mx_q   <= a_q;
				my_q   <= b_q;
				prod_q <= '0;
				mcnt_q <= MCW'(W - 1);
				mph_q  <= 1'b0;
				r0_q   <= p;
				r1_q   <= b_q;
				t0_q   <= '0;
				t1_q   <= one_p;
				pw_q   <= one_p;
				cnt_q  <= CW'(BW - 1);
				if ((cmd_q == pfa_pkg::CMD_ADD) || (cmd_q == pfa_pkg::CMD_SUB) ||
				    (cmd_q == pfa_pkg::CMD_NEG)) begin
					res_q <= u_res;
				end
				if ((cmd_q == pfa_pkg::CMD_DIV) && (b_q == '0)) begin
					err_q <= 1'b1;
				end
			end
			S_MUL: begin
				prod_q <= u_res;
				mph_q  <= ~mph_q;
				if (mph_q) begin
					my_q   <= my_q << 1;
					mcnt_q <= mcnt_q - MCW'(1);
				end
			end
			S_TAKE: begin
				res_q <= prod_q;
			end
			S_POW_SQ: begin
				mx_q   <= pw_q;
				my_q   <= pw_q;
				prod_q <= '0;
				mcnt_q <= MCW'(W - 1);
				mph_q  <= 1'b0;
			end
			S_POW_SQD: begin
				pw_q   <= prod_q;
				mx_q   <= prod_q;
				my_q   <= a_q;
				prod_q <= '0;
				mcnt_q <= MCW'(W - 1);
				mph_q  <= 1'b0;
			end
			S_POW_ML: begin
				pw_q <= prod_q;
			end
			S_POW_NX: begin
				bmag_q <= bmag_q << 1;
				cnt_q  <= cnt_q - CW'(1);
				if (cnt_q == '0) begin
					if (bneg_q) begin
						err_q <= (a_q == '0);
						r0_q  <= p;
						r1_q  <= pw_q;
						t0_q  <= '0;
						t1_q  <= one_p;
					end else begin
						res_q <= pw_q;
					end
				end
			end
			S_INV_TST: begin
				if (r1_q != '0) begin
					// Next Euclid round: divide r0 by r1.
					rem_q <= '0;
					dv_q  <= DW'(r0_q) << (DW - W);
					q_q   <= '0;
					cnt_q <= CW'(W - 1);
				end else if (r0_q != W'(1)) begin
					err_q <= 1'b1;
				end else if (cmd_q == pfa_pkg::CMD_DIV) begin
					mx_q   <= a_q;
					my_q   <= t0_q;
					prod_q <= '0;
					mcnt_q <= MCW'(W - 1);
					mph_q  <= 1'b0;
				end else begin
					res_q <= t0_q;
				end
			end
			S_INV_DIV: begin
				rem_q <= u_res;
				dv_q  <= dv_q << 1;
				q_q   <= {q_q[W-2:0], u_flag};
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == '0) begin
					// Quotient times t1, reduced mod p by the multiply itself.
					mx_q   <= t1_q;
					my_q   <= {q_q[W-2:0], u_flag};
					prod_q <= '0;
					mcnt_q <= MCW'(W - 1);
					mph_q  <= 1'b0;
				end
			end
			S_INV_UPD: begin
				t1_q <= u_res;
				t0_q <= t1_q;
				r0_q <= r1_q;
				r1_q <= rem_q;
			end
			S_DONE: begin
				if (out_load) begin
					ores_q <= err_q ? '0 : res_q;
					oerr_q <= err_q;
					oeq_q  <= (a_q == b_q);
					olt_q  <= (a_q < b_q);
				end
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

endmodule
